>>> rtl/top_n_select_defines.svh
// ----------------------------------------------------------------------------
// top_n_select_defines
// Assertion macros shared by the top-N selection block.
// ----------------------------------------------------------------------------
`ifndef TOP_N_SELECT_DEFINES_SVH
`define TOP_N_SELECT_DEFINES_SVH
`ifndef SYNTHESIS
`define TNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TNS_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define TNS_ASSERT(lbl, prop, msg)
`define TNS_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

>>> rtl/tns_pkg.sv
// ----------------------------------------------------------------------------
// tns_pkg
// Types, codes and helpers of the top-N selection block.
// ----------------------------------------------------------------------------
package tns_pkg;

  localparam int unsigned MaxKeepDefault = 64;
  localparam int unsigned ValueW = 64;
  localparam int unsigned KeepCountW = 7;

  localparam logic [1:0] CmdAdd   = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdClear = 2'd2;

  localparam logic RegKeepCount   = 1'b0;
  localparam logic RegKeepLargest = 1'b1;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [ValueW-1:0] in_value;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0] out_value;
    logic                     has_value;
    logic                     last;
  } out_t;

  typedef struct packed {
    logic append;
    logic latch_in;
    logic clear;
    logic scan_init;
    logic read_init;
    logic scan_run;
    logic rd_mode;
    logic replace;
    logic emit;
    logic emit_empty;
  } ctl_t;

  typedef struct packed {
    logic cnt_lt_lim;
    logic cnt_zero;
    logic scan_done;
    logic pass_last;
  } sts_t;

  function automatic logic is_better(logic signed [ValueW-1:0] a,
                                     logic signed [ValueW-1:0] b,
                                     logic largest);
    logic res;
    res = largest ? (a > b) : (a < b);
    return res;
  endfunction

endpackage

>>> rtl/top_n_select.sv
// ----------------------------------------------------------------------------
// top_n_select
// Keeps the N smallest or largest signed 64-bit values and reads them sorted.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its command adds
// a value, reads out the kept values best first, or clears the store.
// An add while fewer than N values are kept appends the value. An add on a full
// store scans the store for the worst value through the single RAM read port
// and replaces it if the new value is strictly better; ties are not taken.
// A readout runs n selection passes over the RAM for n kept values and yields
// one result per pass, the last one marked.
// An empty store yields a single result with has_value low in the next cycle.
// Results appear on result_o for one cycle with result_valid_o high; the
// receiver cannot stall them. Clear empties the store.
// N and the direction are set over the APB port at byte addresses 0 and 4.
// Reset empties the store and sets N to 1, smallest first; no clearing pass.
// ----------------------------------------------------------------------------
module top_n_select import tns_pkg::*; #(
  parameter int unsigned MaxKeep = MaxKeepDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  in_t         in_i,
  output logic        result_valid_o,
  output out_t        result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [KeepCountW-1:0] keep_count_q, keep_count_d;
  logic                  keep_largest_q, keep_largest_d;
  logic                  cfg_we;
  ctl_t                  ctl;
  sts_t                  sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    keep_count_d   = keep_count_q;
    keep_largest_d = keep_largest_q;
    if (cfg_we) begin
      unique case (paddr[2])
        RegKeepCount:   keep_count_d   = pwdata[KeepCountW-1:0];
        RegKeepLargest: keep_largest_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegKeepCount:   prdata = {{(32 - KeepCountW){1'b0}}, keep_count_q};
      RegKeepLargest: prdata = {31'd0, keep_largest_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q   <= KeepCountW'(1);
      keep_largest_q <= 1'b0;
    end else begin
      keep_count_q   <= keep_count_d;
      keep_largest_q <= keep_largest_d;
    end
  end

  tns_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .cmd_i  (in_i.cmd),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy_o (busy)
  );

  tns_dpath #(.MaxKeep(MaxKeep)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .in_value_i    (in_i.in_value),
    .keep_count_i  (keep_count_q),
    .keep_largest_i(keep_largest_q),
    .sts_o         (sts),
    .res_valid_o   (result_valid_o),
    .res_o         (result_o)
  );

endmodule

>>> rtl/tns_ram.sv
// ----------------------------------------------------------------------------
// tns_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tns_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tns_ctrl.sv
// ----------------------------------------------------------------------------
// tns_ctrl
// Controller state machine that sequences add, readout and clear transactions.
// ----------------------------------------------------------------------------
`include "top_n_select_defines.svh"

module tns_ctrl import tns_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] cmd_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o,
  output logic       busy_o
);

  localparam logic [2:0] SIdle   = 3'd0;
  localparam logic [2:0] SAScan  = 3'd1;
  localparam logic [2:0] SAWrite = 3'd2;
  localparam logic [2:0] SRScan  = 3'd3;
  localparam logic [2:0] SREmit  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          case (cmd_i)
            CmdAdd: begin
              if (sts_i.cnt_lt_lim) begin
                ctl_o.append = 1'b1;
              end else begin
                ctl_o.latch_in  = 1'b1;
                ctl_o.scan_init = 1'b1;
                state_d         = SAScan;
              end
            end
            CmdRead: begin
              if (sts_i.cnt_zero) begin
                ctl_o.emit_empty = 1'b1;
              end else begin
                ctl_o.read_init = 1'b1;
                ctl_o.scan_init = 1'b1;
                state_d         = SRScan;
              end
            end
            CmdClear: ctl_o.clear = 1'b1;
            default: ;
          endcase
        end
      end
      SAScan: begin
        ctl_o.scan_run = 1'b1;
        if (sts_i.scan_done) state_d = SAWrite;
      end
      SAWrite: begin
        ctl_o.replace = 1'b1;
        state_d       = SIdle;
      end
      SRScan: begin
        ctl_o.scan_run = 1'b1;
        ctl_o.rd_mode  = 1'b1;
        if (sts_i.scan_done) state_d = SREmit;
      end
      SREmit: begin
        ctl_o.emit = 1'b1;
        if (sts_i.pass_last) begin
          state_d = SIdle;
        end else begin
          ctl_o.scan_init = 1'b1;
          state_d         = SRScan;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != SIdle);

  `TNS_ASSERT(a_emit_last_idle, (ctl_o.emit && sts_i.pass_last) |=> (state_q == SIdle),
              "Readout did not end after its last result.")
  `TNS_ASSERT(a_replace_once, (state_q == SAWrite) |=> (state_q == SIdle),
              "Replacement step did not return to idle.")
  `TNS_ASSERT_NEVER(a_state_legal, state_q > SREmit, "Controller state is out of range.")

endmodule

>>> rtl/tns_dpath.sv
// ----------------------------------------------------------------------------
// tns_dpath
// Datapath: value store, scan comparator, candidate registers and result stage.
// ----------------------------------------------------------------------------
`include "top_n_select_defines.svh"

module tns_dpath import tns_pkg::*; #(
  parameter int unsigned MaxKeep = MaxKeepDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ctl_t                  ctl_i,
  input  logic signed [ValueW-1:0] in_value_i,
  input  logic [KeepCountW-1:0] keep_count_i,
  input  logic                  keep_largest_i,
  output sts_t                  sts_o,
  output logic                  res_valid_o,
  output out_t                  res_o
);

  localparam int unsigned AddrW = (MaxKeep > 1) ? $clog2(MaxKeep) : 1;
  localparam int unsigned CntW  = $clog2(MaxKeep + 1);
  localparam int unsigned LimW  = (CntW > KeepCountW) ? CntW : KeepCountW;

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   raddr_q, raddr_d;
  logic              dv_q, dv_d;
  logic [AddrW-1:0]  didx_q, didx_d;
  logic              found_q, found_d;
  logic signed [ValueW-1:0] cand_q, cand_d;
  logic [AddrW-1:0]  cand_idx_q, cand_idx_d;
  logic              have_prev_q, have_prev_d;
  logic signed [ValueW-1:0] prev_q, prev_d;
  logic [AddrW-1:0]  prev_idx_q, prev_idx_d;
  logic [CntW-1:0]   emitted_q, emitted_d;
  logic signed [ValueW-1:0] val_q, val_d;
  logic              rv_q, rv_d;
  out_t              res_q, res_d;

  logic [LimW-1:0]   kc, lim;
  logic              issue;
  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;
  logic signed [ValueW-1:0] e;
  logic              eligible, take;

  tns_ram #(.Width(ValueW), .Depth(MaxKeep)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (raddr_q[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    kc = LimW'(keep_count_i);
    if (kc == '0) begin
      lim = LimW'(1);
    end else if (kc > LimW'(MaxKeep)) begin
      lim = LimW'(MaxKeep);
    end else begin
      lim = kc;
    end
  end

  assign e     = $signed(ram_rdata);
  assign issue = ctl_i.scan_run && (raddr_q < cnt_q);

  always_comb begin
    eligible = !have_prev_q || is_better(prev_q, e, keep_largest_i) ||
               ((e == prev_q) && (didx_q > prev_idx_q));
    if (ctl_i.rd_mode) begin
      take = eligible && (!found_q || is_better(e, cand_q, keep_largest_i));
    end else begin
      take = !found_q || is_better(cand_q, e, keep_largest_i);
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    raddr_d     = raddr_q;
    dv_d        = issue;
    didx_d      = raddr_q[AddrW-1:0];
    found_d     = found_q;
    cand_d      = cand_q;
    cand_idx_d  = cand_idx_q;
    have_prev_d = have_prev_q;
    prev_d      = prev_q;
    prev_idx_d  = prev_idx_q;
    emitted_d   = emitted_q;
    val_d       = val_q;
    rv_d        = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[AddrW-1:0];
    ram_wdata   = in_value_i;

    if (issue) raddr_d = raddr_q + CntW'(1);
    if (ctl_i.scan_run && dv_q && take) begin
      found_d    = 1'b1;
      cand_d     = e;
      cand_idx_d = didx_q;
    end
    if (ctl_i.append) begin
      ram_we = 1'b1;
      cnt_d  = cnt_q + CntW'(1);
    end
    if (ctl_i.latch_in) val_d = in_value_i;
    if (ctl_i.clear) cnt_d = '0;
    if (ctl_i.replace) begin
      ram_waddr = cand_idx_q;
      ram_wdata = val_q;
      ram_we    = is_better(val_q, cand_q, keep_largest_i);
    end
    if (ctl_i.read_init) begin
      have_prev_d = 1'b0;
      emitted_d   = '0;
    end
    if (ctl_i.emit) begin
      rv_d            = 1'b1;
      res_d.out_value = cand_q;
      res_d.has_value = 1'b1;
      res_d.last      = sts_o.pass_last;
      have_prev_d     = 1'b1;
      prev_d          = cand_q;
      prev_idx_d      = cand_idx_q;
      emitted_d       = emitted_q + CntW'(1);
    end
    if (ctl_i.emit_empty) begin
      rv_d            = 1'b1;
      res_d.out_value = '0;
      res_d.has_value = 1'b0;
      res_d.last      = 1'b1;
    end
    if (ctl_i.scan_init) begin
      raddr_d = '0;
      dv_d    = 1'b0;
      found_d = 1'b0;
    end
  end

  assign sts_o.cnt_lt_lim = LimW'(cnt_q) < lim;
  assign sts_o.cnt_zero   = (cnt_q == '0);
  assign sts_o.scan_done  = ctl_i.scan_run && dv_q && (CntW'(didx_q) == (cnt_q - CntW'(1)));
  assign sts_o.pass_last  = ((emitted_q + CntW'(1)) == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      raddr_q     <= '0;
      dv_q        <= 1'b0;
      found_q     <= 1'b0;
      have_prev_q <= 1'b0;
      emitted_q   <= '0;
      rv_q        <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      raddr_q     <= raddr_d;
      dv_q        <= dv_d;
      found_q     <= found_d;
      have_prev_q <= have_prev_d;
      emitted_q   <= emitted_d;
      rv_q        <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    didx_q     <= didx_d;
    cand_q     <= cand_d;
    cand_idx_q <= cand_idx_d;
    prev_q     <= prev_d;
    prev_idx_q <= prev_idx_d;
    val_q      <= val_d;
    res_q      <= res_d;
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

  `TNS_ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(MaxKeep), "Kept count exceeds the store depth.")
  `TNS_ASSERT(a_empty_last, (rv_q && !res_q.has_value) |-> res_q.last,
              "Empty result is not marked last.")
  `TNS_ASSERT(a_emit_found, ctl_i.emit |-> found_q,
              "Readout emitted without a candidate.")

endmodule

>>> tb/tb_top_n_select.sv
// ----------------------------------------------------------------------------
// tb_top_n_select
// Self-checking testbench of the top-N selection block.
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the store and the registers. On every
// accepted add, readout or clear it predicts the readout results, and it
// checks each result strobe against them field by field. Directed transactions
// cover empty readouts, extreme values, ties, an unknown command and a change
// of direction. Random phases then run several settings of N and direction,
// including zero, values above the limit and N lowered on a full store.
// ----------------------------------------------------------------------------
module tb_top_n_select;
  import tns_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxKeep = MaxKeepDefault;
  localparam logic [1:0] CmdUnknown = 2'd3;
  localparam logic signed [63:0] ValMin = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ValMax = 64'sh7fff_ffff_ffff_ffff;

  class topn_scoreboard;
    logic [6:0]         keep_n;
    logic               keep_largest;
    logic signed [63:0] kept_q[$];
    out_t               readout_q[$];
    int                 errors;

    function new();
      keep_n = 7'd1;
      keep_largest = 1'b0;
      errors = 0;
    endfunction

    function automatic bit better(logic signed [63:0] a, logic signed [63:0] b);
      return keep_largest ? (a > b) : (a < b);
    endfunction

    function automatic int unsigned limit();
      if (keep_n == 0) return 1;
      if (keep_n > MaxKeep) return MaxKeep;
      return keep_n;
    endfunction

    function void note_config(logic addr_reg, logic [31:0] data);
      if (addr_reg == RegKeepCount) keep_n = data[6:0];
      else keep_largest = data[0];
    endfunction

    function void note_input(in_t item);
      logic signed [63:0] sorted[$];
      logic signed [63:0] key;
      int worst;
      int j;
      out_t res;
      case (item.cmd)
        CmdAdd: begin
          if (kept_q.size() < limit()) begin
            kept_q = {kept_q, item.in_value};
          end else if (kept_q.size() != 0) begin
            worst = 0;
            for (int i = 1; i < kept_q.size(); i++)
              if (better(kept_q[worst], kept_q[i])) worst = i;
            if (better(item.in_value, kept_q[worst])) kept_q[worst] = item.in_value;
          end
        end
        CmdRead: begin
          if (kept_q.size() == 0) begin
            res.out_value = '0;
            res.has_value = 1'b0;
            res.last = 1'b1;
            readout_q = {readout_q, res};
          end else begin
            sorted = kept_q;
            for (int i = 1; i < sorted.size(); i++) begin
              key = sorted[i];
              j = i;
              while (j > 0 && better(key, sorted[j-1])) begin
                sorted[j] = sorted[j-1];
                j--;
              end
              sorted[j] = key;
            end
            foreach (sorted[i]) begin
              res.out_value = sorted[i];
              res.has_value = 1'b1;
              res.last = (i == sorted.size() - 1);
              readout_q = {readout_q, res};
            end
          end
        end
        CmdClear: kept_q.delete();
        default: ;
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check(out_t got);
      out_t exp;
      if (readout_q.size() == 0) begin
        report($sformatf("result %0d with none expected", got.out_value));
        return;
      end
      exp = readout_q.pop_front();
      if (got.out_value !== exp.out_value)
        report($sformatf("out_value %0d, expected %0d", got.out_value, exp.out_value));
      if (got.has_value !== exp.has_value)
        report($sformatf("has_value %0b, expected %0b", got.has_value, exp.has_value));
      if (got.last !== exp.last)
        report($sformatf("last %0b, expected %0b", got.last, exp.last));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_i = '0;
  logic        result_valid_o;
  out_t        result_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  topn_scoreboard sb = new();
  int unsigned    sent = 0;
  int unsigned    gap_pct = 9;

  top_n_select i_dut (
    .clk_i, .rst_ni, .start, .busy, .in_i, .result_valid_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) sb.check(result_o);
  end

  task automatic send_cmd(logic [1:0] c, logic signed [63:0] v);
    int unsigned gap;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 4) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    in_i.cmd = c;
    in_i.in_value = v;
    do @(posedge clk_i); while (busy);
    sb.note_input(in_i);
    sent++;
    if (sent == 120) gap_pct = 62;
    if (sent == 240) gap_pct = 0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.readout_q.size() != 0 || busy) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic addr_reg, logic [31:0] data);
    settle();
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {addr_reg, 2'b00};
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.note_config(addr_reg, data);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic set_mode(logic [31:0] n, logic largest);
    write_reg(RegKeepCount, n);
    write_reg(RegKeepLargest, {31'd0, largest});
  endtask

  function automatic logic signed [63:0] pick_value();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return $signed(64'($urandom_range(16))) - 64'sd8;
      2: begin
        case ($urandom_range(4))
          0: return ValMin;
          1: return ValMax;
          2: return 64'sd0;
          3: return -64'sd1;
          default: return 64'sd1;
        endcase
      end
      default: return {{32{1'b0}}, $urandom} - 64'sh8000_0000;
    endcase
  endfunction

  task automatic random_phase(int unsigned count, int unsigned read_pct,
                              int unsigned clear_pct);
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < read_pct) send_cmd(CmdRead, pick_value());
      else if (r < read_pct + clear_pct) send_cmd(CmdClear, pick_value());
      else if (r < read_pct + clear_pct + 3) send_cmd(CmdUnknown, pick_value());
      else send_cmd(CmdAdd, pick_value());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_cmd(CmdRead, 64'sd0);
    send_cmd(CmdAdd, ValMax);
    send_cmd(CmdAdd, ValMin);
    send_cmd(CmdAdd, ValMin);
    send_cmd(CmdRead, 64'sd0);
    send_cmd(CmdUnknown, ValMax);
    send_cmd(CmdRead, 64'sd0);
    send_cmd(CmdClear, 64'sd0);
    send_cmd(CmdRead, 64'sd0);
    set_mode(32'd4, 1'b1);
    send_cmd(CmdAdd, ValMin);
    send_cmd(CmdAdd, ValMax);
    send_cmd(CmdAdd, 64'sd0);
    send_cmd(CmdAdd, -64'sd1);
    send_cmd(CmdAdd, ValMin);
    send_cmd(CmdAdd, ValMax);
    send_cmd(CmdRead, 64'sd0);
    write_reg(RegKeepLargest, 32'd0);
    send_cmd(CmdRead, 64'sd0);
    send_cmd(CmdAdd, ValMax);
    send_cmd(CmdAdd, 64'sd5);
    send_cmd(CmdRead, 64'sd0);

    set_mode(32'd4, 1'b0);
    random_phase(40, 14, 9);
    set_mode(32'd0, 1'b1);
    random_phase(40, 14, 9);
    set_mode(32'hffff_ff7f, 1'b1);
    random_phase(40, 3, 4);
    set_mode(32'd64, 1'b0);
    random_phase(40, 3, 4);
    set_mode(32'd9, 1'b1);
    random_phase(40, 14, 9);
    set_mode(32'd2, 1'b0);
    random_phase(30, 14, 9);
    set_mode(32'd64, 1'b1);
    send_cmd(CmdClear, 64'sd0);
    random_phase(66, 0, 0);
    send_cmd(CmdRead, 64'sd0);
    set_mode(32'd3, 1'b1);
    random_phase(30, 5, 0);
    send_cmd(CmdRead, 64'sd0);
    set_mode(32'd3, 1'b0);
    random_phase(20, 14, 9);

    settle();
    if (sb.errors == 0) begin
      $display("** top_n_select: PASSED **");
    end else begin
      $display("** top_n_select: FAILED **");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("** top_n_select: FAILED **");
    $finish;
  end

endmodule
